@@ rtl/fau_pkg.sv @@
// Shared codes, operand width and beat types for the fraction arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package fau_pkg;

   // operand width of each numerator and denominator
   localparam int OPERAND_WIDTH = 16;

   // operation codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;

   localparam int RES_NUM_WIDTH = 33;
   localparam int RES_DEN_WIDTH = 31;

   typedef struct packed {
      logic [1:0]                      req_type;
      logic signed [OPERAND_WIDTH-1:0] a_numerator;
      logic signed [OPERAND_WIDTH-1:0] a_denominator;
      logic signed [OPERAND_WIDTH-1:0] b_numerator;
      logic signed [OPERAND_WIDTH-1:0] b_denominator;
   } req_beat_type;

   typedef struct packed {
      logic signed [RES_NUM_WIDTH-1:0] result_numerator;
      logic [RES_DEN_WIDTH-1:0]        result_denominator;
      logic [1:0]                      status;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/fraction_arithmetic_unit.sv @@
// Top level of the fraction arithmetic unit: sequencer, shared multiplier and subtractor.
`timescale 1ns / 1ps
`default_nettype none
// Fraction arithmetic unit. Pulse start with an operation (add, subtract, multiply,
// divide) and two fractions; some cycles later rsp_valid is high for exactly one
// cycle with the exact result in lowest terms, denominator positive, zero as 0/1.
// A zero operand denominator gives status ST_ZERO_DEN, dividing by a zero fraction
// gives ST_DIV_ZERO, both with a 0/0 result. The receiver cannot stall: it must
// take the beat in the cycle it is shown. busy is high from the accepted start
// until the result beat; a new start is taken in the cycle the result is shown.
// Steps, with M = 2*OPERAND_WIDTH: an error beat is decided in S_MUL_A, the first state
// after the accepting edge, and then registered. Otherwise the multiplier states S_MUL_A,
// S_MUL_B and S_MUL_D and the sign-fix state S_SIGN (a zero result is shown right after
// it), then the binary gcd (one subtract or shift per cycle), then two restoring
// divisions of M quotient bits each on the same subtractor. The gcd loop on the single
// subtractor sets most of the spread in the time an item takes.
module fraction_arithmetic_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  fau_pkg::req_beat_type  req_data,
   output logic                         rsp_valid,
   output fau_pkg::rsp_type             rsp_data
);
   import fau_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;          // product width
   localparam int SW = 2 * W + 1;      // signed numerator width
   localparam int MW = 2 * W;          // magnitude width
   localparam int KW = $clog2(MW + 1);
   localparam int CW = $clog2(MW);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MUL_A   = 4'd1;
   localparam logic [3:0] S_MUL_B   = 4'd2;
   localparam logic [3:0] S_MUL_D   = 4'd3;
   localparam logic [3:0] S_SIGN    = 4'd4;
   localparam logic [3:0] S_TWOS    = 4'd5;
   localparam logic [3:0] S_GCD     = 4'd6;
   localparam logic [3:0] S_DIV_NUM = 4'd7;
   localparam logic [3:0] S_DIV_DEN = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   // operand latch
   logic [1:0]          op_ff;
   logic signed [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;

   // working registers
   logic signed [PW-1:0] p1_ff, p1_in, p2_ff, p2_in, dp_ff, dp_in;
   logic                 neg_ff, neg_in;
   logic [MW-1:0]        mag_ff, mag_in, den_ff, den_in;
   logic [MW-1:0]        x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [MW-1:0]        q_ff, q_in, r_ff, r_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   // shared multiplier
   logic signed [W-1:0]  mul_a, mul_b;
   logic signed [PW-1:0] prod;

   // shared subtractor
   logic [MW:0] sub_a, sub_b, diff;
   logic        borrow;

   logic signed [SW-1:0] num_s, num_fix, den_fix, res_num;
   logic [MW:0]          r_shift;
   logic                 zero_den;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // multiplier operand select
   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      unique case (state_ff)
         S_MUL_A: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         S_MUL_B: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         S_MUL_D: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // subtractor: gcd compares x against y, division tries r against g
   assign r_shift = {r_ff, q_ff[MW-1]};
   always_comb begin
      if (state_ff == S_DIV_NUM || state_ff == S_DIV_DEN) begin
         sub_a = r_shift;
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, x_ff};
         sub_b = {1'b0, y_ff};
      end
   end
   assign diff   = sub_a - sub_b;
   assign borrow = diff[MW];

   // combine products, then move the sign onto the numerator
   always_comb begin
      case (op_ff)
         OP_ADD:  num_s = SW'(p1_ff) + SW'(p2_ff);
         OP_SUB:  num_s = SW'(p1_ff) - SW'(p2_ff);
         default: num_s = SW'(p1_ff);
      endcase
      if (dp_ff < 0) begin
         num_fix = -num_s;
         den_fix = -SW'(dp_ff);
      end else begin
         num_fix = num_s;
         den_fix = SW'(dp_ff);
      end
   end

   assign zero_den = (ad_ff == '0) || (bd_ff == '0);
   assign res_num  = neg_ff ? -SW'({1'b0, mag_ff}) : SW'({1'b0, mag_ff});

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      p1_in  = p1_ff;
      p2_in  = p2_ff;
      dp_in  = dp_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      den_in = den_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      g_in   = g_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      k_in   = k_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: begin
            // check operands before spending the long path
            if (zero_den) begin
               rsp_data_in.result_numerator   = '0;
               rsp_data_in.result_denominator = '0;
               rsp_data_in.status             = ST_ZERO_DEN;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (op_ff == OP_DIV && bn_ff == '0) begin
               rsp_data_in.result_numerator   = '0;
               rsp_data_in.result_denominator = '0;
               rsp_data_in.status             = ST_DIV_ZERO;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               p1_in    = prod;
               state_in = S_MUL_B;
            end
         end
         S_MUL_B: begin
            p2_in    = prod;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            dp_in    = prod;
            state_in = S_SIGN;
         end
         S_SIGN: begin
            if (num_fix == '0) begin
               rsp_data_in.result_numerator   = '0;
               rsp_data_in.result_denominator = RES_DEN_WIDTH'(1);
               rsp_data_in.status             = ST_OK;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               neg_in   = num_fix[SW-1];
               mag_in   = num_fix[SW-1] ? MW'(-num_fix) : MW'(num_fix);
               den_in   = MW'(den_fix);
               x_in     = num_fix[SW-1] ? MW'(-num_fix) : MW'(num_fix);
               y_in     = MW'(den_fix);
               k_in     = '0;
               state_in = S_TWOS;
            end
         end
         S_TWOS: begin
            // strip common factors of two
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + KW'(1);
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (x_ff == '0) begin
               g_in     = y_ff << k_ff;
               q_in     = mag_ff;
               r_in     = '0;
               cnt_in   = '0;
               state_in = S_DIV_NUM;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!borrow) begin
               x_in = diff[MW-1:0];
            end else begin
               y_in = MW'(-diff);
            end
         end
         S_DIV_NUM, S_DIV_DEN: begin
            // one quotient bit per cycle
            if (!borrow) begin
               r_in = diff[MW-1:0];
               q_in = {q_ff[MW-2:0], 1'b1};
            end else begin
               r_in = r_shift[MW-1:0];
               q_in = {q_ff[MW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MW - 1)) begin
               cnt_in = '0;
               r_in   = '0;
               if (state_ff == S_DIV_NUM) begin
                  mag_in   = q_in;
                  q_in     = den_ff;
                  state_in = S_DIV_DEN;
               end else begin
                  rsp_data_in.result_numerator   = RES_NUM_WIDTH'(res_num);
                  rsp_data_in.result_denominator = RES_DEN_WIDTH'(q_in);
                  rsp_data_in.status             = ST_OK;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff <= req_data.req_type;
         an_ff <= req_data.a_numerator;
         ad_ff <= req_data.a_denominator;
         bn_ff <= req_data.b_numerator;
         bd_ff <= req_data.b_denominator;
      end
      rsp_data_ff <= rsp_data_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      dp_ff  <= dp_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      g_ff   <= g_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
   end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the fraction arithmetic unit: directed table, then random items.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import fau_pkg::*;

   localparam int W = OPERAND_WIDTH;
   localparam int NUM_RANDOM = 1700;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_beat_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;

   fraction_arithmetic_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // one operand beat
   typedef struct packed {
      logic [1:0]          op;
      logic signed [W-1:0] an;
      logic signed [W-1:0] ad;
      logic signed [W-1:0] bn;
      logic signed [W-1:0] bd;
   } operands_type;

   // directed row: operands plus an optional typed-in result
   typedef struct {
      operands_type operands;
      bit           has_fixed;
      rsp_type      fixed;
   } row_type;

   rsp_type pending_fractions[$];
   int      mismatch_count = 0;
   int      result_count   = 0;
   int      error_count    = 0;
   bit      op_seen[4];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Reduce a fraction the way the block must: positive denominator, gcd of
   // magnitudes, zero as 0/1, errors as a 0/0 result with a status code.
   function automatic rsp_type reduce_fraction(operands_type x);
      rsp_type r;
      longint an, ad, bn, bd, num, den, g, p, q, t;
      an = longint'(x.an);
      ad = longint'(x.ad);
      bn = longint'(x.bn);
      bd = longint'(x.bd);
      r = '0;
      if (ad == 0 || bd == 0) begin
         r.status = ST_ZERO_DEN;
         return r;
      end
      if (x.op == OP_DIV && bn == 0) begin
         r.status = ST_DIV_ZERO;
         return r;
      end
      case (x.op)
         OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
         OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
         OP_MUL: begin num = an * bn; den = ad * bd; end
         default: begin num = an * bd; den = ad * bn; end
      endcase
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      r.status = ST_OK;
      if (num == 0) begin
         r.result_denominator = RES_DEN_WIDTH'(1);
         return r;
      end
      p = (num < 0) ? -num : num;
      q = den;
      while (q != 0) begin
         t = p % q;
         p = q;
         q = t;
      end
      g = p;
      r.result_numerator   = RES_NUM_WIDTH'(num / g);
      r.result_denominator = RES_DEN_WIDTH'(den / g);
      return r;
   endfunction

   // Compare each result beat with the oldest expectation; rsp_valid cannot stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         result_count++;
         if (pending_fractions.size() == 0) begin
            if (mismatch_count < 10)
               $display("ERROR: unexpected result beat %h", rsp_data);
            mismatch_count++;
         end else begin
            rsp_type exp_r;
            exp_r = pending_fractions.pop_front();
            if (exp_r.status != ST_OK) error_count++;
            if (rsp_data.result_numerator !== exp_r.result_numerator ||
                rsp_data.result_denominator !== exp_r.result_denominator ||
                rsp_data.status !== exp_r.status) begin
               if (mismatch_count < 10)
                  $display("ERROR: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                           exp_r.result_numerator, exp_r.result_denominator,
                           exp_r.status, rsp_data.result_numerator,
                           rsp_data.result_denominator, rsp_data.status);
               mismatch_count++;
            end
         end
      end
   end

   // Drive one beat: hold start until the edge that sees busy low, then drop it.
   // A follow-on beat keeps start high through the next call without a glitch.
   task automatic send_beat(operands_type x, bit hold_start);
      req_beat_type beat;
      beat.req_type      = x.op;
      beat.a_numerator   = x.an;
      beat.a_denominator = x.ad;
      beat.b_numerator   = x.bn;
      beat.b_denominator = x.bd;
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      op_seen[x.op] = 1'b1;
      if (!hold_start) start <= 1'b0;
   endtask

   function automatic logic signed [W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sd32767;
         2: return 16'(signed'($urandom_range(0, 4)) - 2);
         3: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic operands_type random_operands();
      operands_type x;
      x.op = 2'($urandom_range(0, 3));
      x.an = pick_value();
      x.ad = pick_value();
      x.bn = pick_value();
      x.bd = pick_value();
      // keep most denominators nonzero so the arithmetic path dominates
      if (x.ad == 0 && $urandom_range(0, 3) != 0) x.ad = 1;
      if (x.bd == 0 && $urandom_range(0, 3) != 0) x.bd = -1;
      if (x.op == OP_DIV && x.bn == 0 && $urandom_range(0, 3) != 0) x.bn = 3;
      return x;
   endfunction

   function automatic rsp_type fixed_fraction(longint n, longint d, logic [1:0] st);
      rsp_type r;
      r.result_numerator   = RES_NUM_WIDTH'(n);
      r.result_denominator = RES_DEN_WIDTH'(d);
      r.status             = st;
      return r;
   endfunction

   row_type directed_rows[$];

   task automatic add_row(logic [1:0] op, int an, int ad, int bn, int bd,
                          bit has_fixed, rsp_type fixed);
      row_type row;
      row.operands  = '{op, an[W-1:0], ad[W-1:0], bn[W-1:0], bd[W-1:0]};
      row.has_fixed = has_fixed;
      row.fixed     = fixed;
      directed_rows.push_back(row);
   endtask

   initial begin
      rsp_type nil_r;
      operands_type x;
      bit idle_enable;
      nil_r = '0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;

      // directed table; fixed results only where they are obvious
      add_row(OP_ADD, 1, 2, 1, 2, 1, fixed_fraction(1, 1, ST_OK));
      add_row(OP_SUB, 1, 2, 1, 2, 1, fixed_fraction(0, 1, ST_OK));
      add_row(OP_MUL, 0, 5, 7, 3, 1, fixed_fraction(0, 1, ST_OK));
      add_row(OP_DIV, 3, 4, 0, 5, 1, fixed_fraction(0, 0, ST_DIV_ZERO));
      add_row(OP_DIV, 3, 0, 0, 5, 1, fixed_fraction(0, 0, ST_ZERO_DEN));
      add_row(OP_ADD, 1, 2, 1, 0, 1, fixed_fraction(0, 0, ST_ZERO_DEN));
      add_row(OP_MUL, 0, 0, 0, 0, 1, fixed_fraction(0, 0, ST_ZERO_DEN));
      add_row(OP_ADD, -32768, 1, -32768, 1, 1,
              fixed_fraction(-64'sd65536, 1, ST_OK));
      add_row(OP_SUB, 32767, 1, -32768, 1, 1, fixed_fraction(65535, 1, ST_OK));
      add_row(OP_MUL, -32768, 1, -32768, 1, 1,
              fixed_fraction(64'sd1073741824, 1, ST_OK));
      add_row(OP_MUL, 1, -32768, 1, -32768, 1,
              fixed_fraction(1, 64'd1073741824, ST_OK));
      add_row(OP_DIV, 1, 32767, 32767, 1, 1, fixed_fraction(1, 1073676289, ST_OK));
      add_row(OP_ADD, 3, -4, 1, -4, 1, fixed_fraction(-1, 1, ST_OK));
      add_row(OP_DIV, -6, 4, -3, 2, 1, fixed_fraction(1, 1, ST_OK));
      add_row(OP_SUB, -1, -1, 0, 7, 1, fixed_fraction(1, 1, ST_OK));
      add_row(OP_DIV, 32767, -32768, -32768, 32767, 0, nil_r);
      add_row(OP_ADD, 12345, -4321, -9999, 777, 0, nil_r);
      add_row(OP_SUB, -32768, 32767, 32767, -32768, 0, nil_r);
      add_row(OP_MUL, -1, -1, -1, -1, 1, fixed_fraction(1, 1, ST_OK));
      add_row(OP_DIV, 0, -3, 5, 9, 1, fixed_fraction(0, 1, ST_OK));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: back to back, predictor cross-checks the typed-in rows
      foreach (directed_rows[i]) begin
         rsp_type pred;
         pred = reduce_fraction(directed_rows[i].operands);
         if (directed_rows[i].has_fixed && pred !== directed_rows[i].fixed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: row %0d table %h vs predictor %h",
                        i, directed_rows[i].fixed, pred);
         end
         pending_fractions.push_back(directed_rows[i].has_fixed ?
                                     directed_rows[i].fixed : pred);
         send_beat(directed_rows[i].operands, i != directed_rows.size() - 1);
      end

      // hold off the sender until every expected result is in
      while (pending_fractions.size() != 0) @(posedge clock);

      // random part; idle bursts, none in the last stretch
      idle_enable = 1'b1;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         bit gap;
         if (n == NUM_RANDOM - 200) idle_enable = 1'b0;
         x = random_operands();
         pending_fractions.push_back(reduce_fraction(x));
         gap = idle_enable && ($urandom_range(0, 3) == 0);
         send_beat(x, !gap && n != NUM_RANDOM - 1);
         if (gap) repeat ($urandom_range(1, 15)) @(posedge clock);
      end

      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d results, %0d error status, ops add/sub/mul/div seen %0d%0d%0d%0d",
               result_count, error_count, op_seen[0], op_seen[1], op_seen[2],
               op_seen[3]);
      if (mismatch_count == 0 && pending_fractions.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog: about 1700 items plus idle gaps, taken well over
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
rtl/fau_pkg.sv
rtl/fraction_arithmetic_unit.sv
tb/tb_top.sv
